[rtl/tfsp_pkg.sv]
// Shared constants, register codes and stage types for the thermal frame statistics block.
package tfsp_pkg;

  localparam int FRAME_PIXELS_DEF = 64;

  localparam int PIXEL_W = 12;
  localparam int IDX_W = 6;
  localparam int AVG_W = 20;
  localparam int THR_W = 12;
  localparam int HOLD_W = 8;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_FRAMES = 1'd1;

  localparam logic [THR_W-1:0] THR_RESET = 12'd16;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd10;

  // The mean in 1/1024 C is the sum scaled by 256 and divided by the frame size.
  localparam int AVG_SCALE_SHIFT = 8;
  localparam int DIV_SHIFT = 20;
  localparam int RECIP_W = DIV_SHIFT + AVG_SCALE_SHIFT + 1;

  typedef struct packed {
    logic signed [PIXEL_W-1:0] max_value;
    logic signed [PIXEL_W-1:0] min_value;
    logic [IDX_W-1:0]          max_index;
    logic [IDX_W-1:0]          min_index;
  } stats_t;

  typedef struct packed {
    stats_t stats;
    logic   person_present;
    logic   presence_changed;
    logic   sum_neg;
  } res_t;

endpackage

[rtl/tfsp_frame_acc.sv]
// Per-frame running maximum, minimum, positions and sum, with the frame-end stage register.
module tfsp_frame_acc
  import tfsp_pkg::*;
#(
  parameter int FRAME_PIXELS = FRAME_PIXELS_DEF,
  localparam int CNT_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1,
  localparam int SUM_W = PIXEL_W + CNT_W
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [PIXEL_W-1:0] in_pixel_value,
  output logic                      st_valid,
  input  logic                      st_ready,
  output stats_t                    st_stats,
  output logic signed [SUM_W-1:0]   st_sum
);

  logic [CNT_W-1:0]          cnt_r;
  logic signed [PIXEL_W-1:0] max_r;
  logic signed [PIXEL_W-1:0] min_r;
  logic [IDX_W-1:0]          max_idx_r;
  logic [IDX_W-1:0]          min_idx_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic                      st_v_r;
  stats_t                    st_stats_r;
  logic signed [SUM_W-1:0]   st_sum_r;

  logic                      first;
  logic                      last;
  logic                      accept;
  logic                      take_max;
  logic                      take_min;
  logic signed [PIXEL_W-1:0] max_nxt;
  logic signed [PIXEL_W-1:0] min_nxt;
  logic [IDX_W-1:0]          max_idx_nxt;
  logic [IDX_W-1:0]          min_idx_nxt;
  logic signed [SUM_W-1:0]   sum_nxt;
  logic [CNT_W-1:0]          cnt_nxt;

  always_comb begin
    first = (cnt_r == '0);
    last = (cnt_r == CNT_W'(FRAME_PIXELS - 1));
    in_stall = st_v_r && !st_ready;
    accept = in_valid && !in_stall;
    take_max = first || (in_pixel_value > max_r);
    take_min = first || (in_pixel_value < min_r);
    max_nxt = take_max ? in_pixel_value : max_r;
    min_nxt = take_min ? in_pixel_value : min_r;
    max_idx_nxt = take_max ? IDX_W'(cnt_r) : max_idx_r;
    min_idx_nxt = take_min ? IDX_W'(cnt_r) : min_idx_r;
    sum_nxt = (first ? SUM_W'(0) : sum_r) + SUM_W'(in_pixel_value);
    cnt_nxt = last ? '0 : CNT_W'(cnt_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      st_v_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
      if (accept && last) begin
        st_v_r <= 1'b1;
      end else if (st_ready) begin
        st_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      max_r <= max_nxt;
      min_r <= min_nxt;
      max_idx_r <= max_idx_nxt;
      min_idx_r <= min_idx_nxt;
      sum_r <= sum_nxt;
    end
    if (accept && last) begin
      st_stats_r.max_value <= max_nxt;
      st_stats_r.min_value <= min_nxt;
      st_stats_r.max_index <= max_idx_nxt;
      st_stats_r.min_index <= min_idx_nxt;
      st_sum_r <= sum_nxt;
    end
  end

  assign st_valid = st_v_r;
  assign st_stats = st_stats_r;
  assign st_sum = st_sum_r;

endmodule

[rtl/tfsp_presence.sv]
// Configuration registers, presence hysteresis and the reciprocal multiply of the frame sum.
module tfsp_presence
  import tfsp_pkg::*;
#(
  parameter int FRAME_PIXELS = FRAME_PIXELS_DEF,
  localparam int CNT_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1,
  localparam int SUM_W = PIXEL_W + CNT_W,
  localparam int QW = SUM_W + AVG_SCALE_SHIFT
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_write_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  stats_t                  up_stats,
  input  logic signed [SUM_W-1:0] up_sum,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output res_t                    dn_res,
  output logic [SUM_W-1:0]        dn_mag,
  output logic [QW-1:0]           dn_quot
);

  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((longint'(1) << (DIV_SHIFT + AVG_SCALE_SHIFT)) / FRAME_PIXELS);

  logic [THR_W-1:0]  thr_r;
  logic [HOLD_W-1:0] hold_r;
  logic              present_r;
  logic [HOLD_W-1:0] rel_r;
  logic              v_r;
  res_t              res_r;
  logic [SUM_W-1:0]  mag_r;
  logic [QW-1:0]     quot_r;

  logic                       take;
  logic [PIXEL_W:0]           spread;
  logic                       high;
  logic                       present_nxt;
  logic [HOLD_W-1:0]          rel_nxt;
  logic                       neg;
  logic [SUM_W-1:0]           mag;
  logic [SUM_W+RECIP_W-1:0]   product;

  always_comb begin
    up_ready = !v_r || dn_ready;
    take = up_valid && up_ready;
    spread = {up_stats.max_value[PIXEL_W-1], up_stats.max_value}
           - {up_stats.min_value[PIXEL_W-1], up_stats.min_value};
    high = spread > {1'b0, thr_r};
    present_nxt = present_r;
    rel_nxt = rel_r;
    if (high) begin
      if (!present_r) begin
        rel_nxt = hold_r;
      end
      present_nxt = 1'b1;
    end else if (present_r) begin
      if (rel_r <= HOLD_W'(1)) begin
        rel_nxt = '0;
        present_nxt = 1'b0;
      end else begin
        rel_nxt = rel_r - 1'b1;
      end
    end
    neg = up_sum[SUM_W-1];
    mag = neg ? (~$unsigned(up_sum) + 1'b1) : $unsigned(up_sum);
    product = (SUM_W + RECIP_W)'(mag) * (SUM_W + RECIP_W)'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      hold_r <= HOLD_RESET;
      present_r <= 1'b0;
      rel_r <= '0;
      v_r <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_SPREAD_THRESHOLD: begin
            thr_r <= cfg_data[THR_W-1:0];
          end
          CFG_HOLD_FRAMES: begin
            hold_r <= cfg_data[HOLD_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (take) begin
        present_r <= present_nxt;
        rel_r <= rel_nxt;
        v_r <= 1'b1;
      end else if (dn_ready) begin
        v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r.stats <= up_stats;
      res_r.person_present <= present_nxt;
      res_r.presence_changed <= present_nxt != present_r;
      res_r.sum_neg <= neg;
      mag_r <= mag;
      quot_r <= product[DIV_SHIFT +: QW];
    end
  end

  assign dn_valid = v_r;
  assign dn_res = res_r;
  assign dn_mag = mag_r;
  assign dn_quot = quot_r;

endmodule

[rtl/tfsp_avg_out.sv]
// Quotient correction, sign restore and the result register that drives the output channel.
module tfsp_avg_out
  import tfsp_pkg::*;
#(
  parameter int FRAME_PIXELS = FRAME_PIXELS_DEF,
  localparam int CNT_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1,
  localparam int SUM_W = PIXEL_W + CNT_W,
  localparam int QW = SUM_W + AVG_SCALE_SHIFT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  res_t                      up_res,
  input  logic [SUM_W-1:0]          up_mag,
  input  logic [QW-1:0]             up_quot,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [PIXEL_W-1:0] out_max_value,
  output logic signed [PIXEL_W-1:0] out_min_value,
  output logic [IDX_W-1:0]          out_max_index,
  output logic [IDX_W-1:0]          out_min_index,
  output logic signed [AVG_W-1:0]   out_average,
  output logic                      out_person_present,
  output logic                      out_presence_changed
);

  localparam int N_W = $clog2(FRAME_PIXELS + 1);
  localparam int PW = QW + N_W;

  logic                    v_r;
  res_t                    res_r;
  logic signed [AVG_W-1:0] avg_r;

  logic          take;
  logic [PW-1:0] num;
  logic [PW-1:0] prod;
  logic [PW-1:0] rem;
  logic          bump;
  logic [QW-1:0] qmag;
  logic [QW:0]   qsig;

  // The estimate from the reciprocal is at most one below the true quotient.
  always_comb begin
    up_ready = !v_r || !out_stall;
    take = up_valid && up_ready;
    num = PW'({up_mag, AVG_SCALE_SHIFT'(0)});
    prod = PW'(up_quot) * PW'(FRAME_PIXELS);
    rem = num - prod;
    bump = rem >= PW'(FRAME_PIXELS);
    qmag = up_quot + QW'(bump);
    qsig = up_res.sum_neg ? (~{1'b0, qmag} + 1'b1) : {1'b0, qmag};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      if (take) begin
        v_r <= 1'b1;
      end else if (!out_stall) begin
        v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= up_res;
      avg_r <= AVG_W'(qsig);
    end
  end

  assign out_valid = v_r;
  assign out_max_value = res_r.stats.max_value;
  assign out_min_value = res_r.stats.min_value;
  assign out_max_index = res_r.stats.max_index;
  assign out_min_index = res_r.stats.min_index;
  assign out_average = avg_r;
  assign out_person_present = res_r.person_present;
  assign out_presence_changed = res_r.presence_changed;

endmodule

[rtl/thermal_frame_stats_presence.sv]
// Top level of the thermal frame statistics and presence detection block.
// Pixels are taken one per clock cycle while in_stall is low, in frame order, FRAME_PIXELS
// to a frame. On the last pixel of each frame one result is produced: the maximum and minimum
// with the position of the first pixel holding each, the mean in 1/1024 C truncated toward
// zero, and the presence flag with a change marker. A frame's result passes through the
// frame-end register, the presence and reciprocal-multiply register, and the output register.
// Every stage advances independently, so the input keeps taking one pixel per cycle while
// results wait, and only backs up once all three stages hold an untaken frame result.
// Configuration writes take effect for the next frame result that enters the presence stage;
// the user must make them while no frame is in progress, and the block does not enforce this.
module thermal_frame_stats_presence
  import tfsp_pkg::*;
#(
  parameter int FRAME_PIXELS = FRAME_PIXELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [PIXEL_W-1:0] in_pixel_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [PIXEL_W-1:0] out_max_value,
  output logic signed [PIXEL_W-1:0] out_min_value,
  output logic [IDX_W-1:0]          out_max_index,
  output logic [IDX_W-1:0]          out_min_index,
  output logic signed [AVG_W-1:0]   out_average,
  output logic                      out_person_present,
  output logic                      out_presence_changed,
  input  logic                      cfg_write_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int CNT_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int SUM_W = PIXEL_W + CNT_W;
  localparam int QW = SUM_W + AVG_SCALE_SHIFT;

  logic                    st_valid;
  logic                    st_ready;
  stats_t                  st_stats;
  logic signed [SUM_W-1:0] st_sum;
  logic                    pr_valid;
  logic                    pr_ready;
  res_t                    pr_res;
  logic [SUM_W-1:0]        pr_mag;
  logic [QW-1:0]           pr_quot;

  tfsp_frame_acc #(
    .FRAME_PIXELS(FRAME_PIXELS)
  ) u_frame_acc (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_pixel_value(in_pixel_value),
    .st_valid(st_valid),
    .st_ready(st_ready),
    .st_stats(st_stats),
    .st_sum(st_sum)
  );

  tfsp_presence #(
    .FRAME_PIXELS(FRAME_PIXELS)
  ) u_presence (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .up_valid(st_valid),
    .up_ready(st_ready),
    .up_stats(st_stats),
    .up_sum(st_sum),
    .dn_valid(pr_valid),
    .dn_ready(pr_ready),
    .dn_res(pr_res),
    .dn_mag(pr_mag),
    .dn_quot(pr_quot)
  );

  tfsp_avg_out #(
    .FRAME_PIXELS(FRAME_PIXELS)
  ) u_avg_out (
    .clk(clk),
    .rst_n(rst_n),
    .up_valid(pr_valid),
    .up_ready(pr_ready),
    .up_res(pr_res),
    .up_mag(pr_mag),
    .up_quot(pr_quot),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_max_value(out_max_value),
    .out_min_value(out_min_value),
    .out_max_index(out_max_index),
    .out_min_index(out_min_index),
    .out_average(out_average),
    .out_person_present(out_person_present),
    .out_presence_changed(out_presence_changed)
  );

endmodule
